@@ sv/nns_pkg.sv @@
// Package for the nearest-neighbor image scaler: sizes, register and opcode
// codes, the pipeline sideband word and the side-size saturation helper.
// No dependencies; the divider, the core and the testbench import it.
package nns_pkg;

  localparam int MAX_SIDE   = 256;
  localparam int SCALE_FRAC = 12;
  localparam int CHANNELS   = 3;

  // Fixed field widths of the ports.
  localparam int COORD_W   = 12;
  localparam int SIZE_W    = 9;
  localparam int SCALE_W   = 16;
  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 2;
  localparam int PIX_W     = 8 * CHANNELS;

  // Derived sizes.
  localparam int SIDE_W     = $clog2(MAX_SIDE);
  localparam int SSIDE_W    = SIDE_W + 1;
  localparam int ADDR_W     = 2 * SIDE_W;
  localparam int DEPTH      = MAX_SIDE * MAX_SIDE;
  localparam int NUM_W      = COORD_W + SCALE_FRAC;
  localparam int PROD_W     = SSIDE_W + SCALE_W;
  localparam int DIV_STEPS  = 2;
  localparam int DIV_STAGES = (SIDE_W + DIV_STEPS - 1) / DIV_STEPS;
  localparam int DIV_LAT    = DIV_STAGES + 1;
  localparam int OUT_LAT    = DIV_LAT + 2;

  localparam logic [SIZE_W-1:0]  SIZE_RESET  = SIZE_W'(256);
  localparam logic [SCALE_W-1:0] SCALE_RESET = SCALE_W'(4096);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SRC_WIDTH  = 2'd0,
    REG_SRC_HEIGHT = 2'd1,
    REG_H_SCALE    = 2'd2,
    REG_V_SCALE    = 2'd3
  } cfg_reg_t;

  typedef enum logic {
    OP_WRITE = 1'b0,
    OP_READ  = 1'b1
  } opcode_t;

  typedef struct packed {
    logic              valid;
    logic              rd;
    logic              oor;
    logic              wr_ok;
    logic [ADDR_W-1:0] wr_addr;
    logic [PIX_W-1:0]  pix;
  } sb_t;

  // A size of zero counts as one, a size above the store counts as the store.
  function automatic logic [SSIDE_W-1:0] sat_side(input logic [SIZE_W-1:0] v);
    logic [SSIDE_W-1:0] res;
    if (v == '0) begin
      res = SSIDE_W'(1);
    end else if (32'(v) > 32'(MAX_SIDE)) begin
      res = SSIDE_W'(MAX_SIDE);
    end else begin
      res = SSIDE_W'(v);
    end
    return res;
  endfunction

endpackage

@@ sv/nns_ram.sv @@
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Standalone; used for the source frame store.
module nns_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 65536
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

@@ sv/nns_divider.sv @@
// Pipelined restoring divider that maps one output coordinate to its source
// coordinate with round-half-down and clamping. Depends on nns_pkg.
module nns_divider import nns_pkg::*; (
  input  logic               clk,
  input  logic [NUM_W-1:0]   num,
  input  logic [SCALE_W-1:0] scale,
  input  logic [SSIDE_W-1:0] side,
  output logic [SIDE_W-1:0]  quo
);

  logic [NUM_W-1:0]  rem_r [DIV_STAGES];
  logic [SIDE_W-1:0] q_r   [DIV_STAGES];
  logic [SIDE_W-1:0] quo_r;
  logic [NUM_W-1:0]  scale_ext;

  assign scale_ext = NUM_W'(scale);

  // Each stage resolves DIV_STEPS quotient bits, most significant first. For an
  // in-range request the quotient is below the side, so SIDE_W bits suffice.
  for (genvar k = 0; k < DIV_STAGES; k++) begin : g_stage
    logic [NUM_W-1:0]  rem_in;
    logic [NUM_W-1:0]  rem_nxt;
    logic [SIDE_W-1:0] q_in;
    logic [SIDE_W-1:0] q_nxt;

    if (k == 0) begin : g_first
      assign rem_in = num;
      assign q_in   = '0;
    end else begin : g_next
      assign rem_in = rem_r[k-1];
      assign q_in   = q_r[k-1];
    end

    always_comb begin
      int b;
      rem_nxt = rem_in;
      q_nxt   = q_in;
      for (int j = 0; j < DIV_STEPS; j++) begin
        b = SIDE_W - 1 - (k * DIV_STEPS + j);
        if (b >= 0) begin
          if ((rem_nxt >> b) >= scale_ext) begin
            rem_nxt = rem_nxt - (scale_ext << b);
            q_nxt   = q_nxt | (SIDE_W'(1) << b);
          end
        end
      end
    end

    always_ff @(posedge clk) begin
      rem_r[k] <= rem_nxt;
      q_r[k]   <= q_nxt;
    end
  end

  // Round up only when the remainder is strictly above half the scale, then
  // clamp to the last source row or column.
  logic                rnd_up;
  logic [SIDE_W:0]     q_rnd;
  logic [SSIDE_W-1:0]  lim;
  logic [SIDE_W-1:0]   quo_nxt;

  always_comb begin
    rnd_up  = {rem_r[DIV_STAGES-1], 1'b0} > {1'b0, scale_ext};
    q_rnd   = {1'b0, q_r[DIV_STAGES-1]} + (SIDE_W + 1)'(rnd_up);
    lim     = side - SSIDE_W'(1);
    quo_nxt = (32'(q_rnd) > 32'(lim)) ? lim[SIDE_W-1:0] : q_rnd[SIDE_W-1:0];
  end

  always_ff @(posedge clk) begin
    quo_r <= quo_nxt;
  end

  assign quo = quo_r;

endmodule

@@ sv/nearest_neighbour_image_scaler_core.sv @@
// Top level of the nearest-neighbor image scaler: configuration registers,
// request pipeline, frame store. Depends on nns_pkg, nns_divider, nns_ram.
//
// Usage: a word is taken at each rising edge with start high and busy low;
// busy stays low, so one word can be issued every clock. A write word
// (opcode 0) stores pixel_in at (row, column) when that lies inside the
// source size and produces no result. A read word (opcode 1) names an output
// position; it is mapped through both scale registers to a source position
// and the stored pixel comes back on out_pixel_out, marked by out_valid for
// one cycle. Positions outside the scaled image return zero with
// out_out_of_range set. Reads and writes stay in issue order, so a read sees
// every write issued before it.
// Path of a result word: input capture, the divider pipeline (two quotient
// bits per stage plus a rounding stage), then the registered frame store
// read that drives the outputs.
// Throughput: one word per clock, sustained. The receiver cannot stall.
// Configuration: cfg_we writes register cfg_index at the edge; write only
// while no word is in flight. Reset restores 256 x 256 at scale 1.0 and
// clears the pipeline valid bits; the frame store keeps its contents and
// must be written before it is read.
module nearest_neighbour_image_scaler_core import nns_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  logic                 in_opcode,
  input  logic [COORD_W-1:0]   in_row,
  input  logic [COORD_W-1:0]   in_column,
  input  logic [PIX_W-1:0]     in_pixel_in,
  output logic                 out_valid,
  output logic [PIX_W-1:0]     out_pixel_out,
  output logic                 out_out_of_range,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata
);

  // Configuration registers.
  logic [SIZE_W-1:0]  src_width_r;
  logic [SIZE_W-1:0]  src_height_r;
  logic [SCALE_W-1:0] h_scale_r;
  logic [SCALE_W-1:0] v_scale_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_width_r  <= SIZE_RESET;
      src_height_r <= SIZE_RESET;
      h_scale_r    <= SCALE_RESET;
      v_scale_r    <= SCALE_RESET;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_SRC_WIDTH:  src_width_r  <= cfg_wdata[SIZE_W-1:0];
        REG_SRC_HEIGHT: src_height_r <= cfg_wdata[SIZE_W-1:0];
        REG_H_SCALE:    h_scale_r    <= cfg_wdata[SCALE_W-1:0];
        REG_V_SCALE:    v_scale_r    <= cfg_wdata[SCALE_W-1:0];
        default: ;
      endcase
    end
  end

  logic [SSIDE_W-1:0] w_sat;
  logic [SSIDE_W-1:0] h_sat;

  assign w_sat = sat_side(src_width_r);
  assign h_sat = sat_side(src_height_r);
  assign busy  = 1'b0;

  // Stage 1: input capture, write bounds check and scaled-size products.
  logic               accept;
  logic               s1_valid_r;
  logic               s1_rd_r;
  logic               s1_wr_ok_r;
  logic [COORD_W-1:0] s1_row_r;
  logic [COORD_W-1:0] s1_col_r;
  logic [PIX_W-1:0]   s1_pix_r;
  logic [PROD_W-1:0]  prod_w_r;
  logic [PROD_W-1:0]  prod_h_r;

  assign accept = start && !busy;

  always_ff @(posedge clk) begin
    s1_rd_r    <= (in_opcode == OP_READ);
    s1_wr_ok_r <= (32'(in_row) < 32'(h_sat)) && (32'(in_column) < 32'(w_sat));
    s1_row_r   <= in_row;
    s1_col_r   <= in_column;
    s1_pix_r   <= in_pixel_in;
    prod_w_r   <= PROD_W'(w_sat) * PROD_W'(h_scale_r);
    prod_h_r   <= PROD_W'(h_sat) * PROD_W'(v_scale_r);
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= accept;
    end
  end

  // Sideband line that runs beside the two dividers.
  sb_t sb_r [DIV_LAT];
  sb_t sb_nxt;
  sb_t sb_last;

  always_comb begin
    sb_nxt.valid   = s1_valid_r;
    sb_nxt.rd      = s1_rd_r;
    sb_nxt.oor     = (32'(s1_col_r) >= 32'(prod_w_r[PROD_W-1:SCALE_FRAC]))
                  || (32'(s1_row_r) >= 32'(prod_h_r[PROD_W-1:SCALE_FRAC]))
                  || (h_scale_r == '0) || (v_scale_r == '0);
    sb_nxt.wr_ok   = s1_wr_ok_r;
    sb_nxt.wr_addr = {s1_row_r[SIDE_W-1:0], s1_col_r[SIDE_W-1:0]};
    sb_nxt.pix     = s1_pix_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < DIV_LAT; k++) begin
        sb_r[k] <= '0;
      end
    end else begin
      sb_r[0] <= sb_nxt;
      for (int k = 1; k < DIV_LAT; k++) begin
        sb_r[k] <= sb_r[k-1];
      end
    end
  end

  assign sb_last = sb_r[DIV_LAT-1];

  // Coordinate mapping, one divider per axis.
  logic [SIDE_W-1:0] src_x;
  logic [SIDE_W-1:0] src_y;

  nns_divider u_div_x (
    .clk   (clk),
    .num   (NUM_W'(s1_col_r) << SCALE_FRAC),
    .scale (h_scale_r),
    .side  (w_sat),
    .quo   (src_x)
  );

  nns_divider u_div_y (
    .clk   (clk),
    .num   (NUM_W'(s1_row_r) << SCALE_FRAC),
    .scale (v_scale_r),
    .side  (h_sat),
    .quo   (src_y)
  );

  // Frame store. Writes and reads are issued from the same stage, so their
  // order matches the order in which the words were taken.
  logic             ram_we;
  logic [PIX_W-1:0] ram_rdata;

  assign ram_we = sb_last.valid && !sb_last.rd && sb_last.wr_ok;

  nns_ram #(
    .WIDTH (PIX_W),
    .DEPTH (DEPTH)
  ) u_frame_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (sb_last.wr_addr),
    .wdata (sb_last.pix),
    .raddr ({src_y, src_x}),
    .rdata (ram_rdata)
  );

  // Result stage.
  logic out_valid_r;
  logic oor_r;

  always_ff @(posedge clk) begin
    oor_r <= sb_last.oor;
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= sb_last.valid && sb_last.rd;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_out_of_range = oor_r;
  assign out_pixel_out    = oor_r ? '0 : ram_rdata;

  // Every result word goes back to a read word taken a fixed time earlier.
  a_result_from_read: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ($past(accept, OUT_LAT) && $past(in_opcode == OP_READ, OUT_LAT)))
    else $error("result word without a matching read word");

  // A write word never produces a result word.
  a_write_silent: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(accept, OUT_LAT) && $past(in_opcode == OP_WRITE, OUT_LAT)) |-> !out_valid)
    else $error("write word produced a result word");

  // The frame store is never written while a read sits in the issue stage.
  a_no_write_on_read: assert property (@(posedge clk) disable iff (!rst_n)
    (sb_last.valid && sb_last.rd) |-> !ram_we)
    else $error("frame store write during a read slot");

endmodule

@@ tb/sv/nearest_neighbour_image_scaler_core_test.sv @@
// Self-checking testbench for nearest_neighbour_image_scaler_core: directed and random
// pixel writes and scaled reads, checked against an in-bench model of the scaler.
// Depends on nns_pkg and the RTL of the core.
module nearest_neighbour_image_scaler_core_test import nns_pkg::*;;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int SETTLE       = OUT_LAT + 4;
  localparam int DRAIN_LIMIT  = 1000;
  localparam int PHASES       = 8;
  localparam int PHASE_WORDS  = 202;

  typedef struct {
    logic [PIX_W-1:0] pixel;
    logic             flagged;
  } scaled_px_t;

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 start;
  logic                 busy;
  logic                 in_opcode;
  logic [COORD_W-1:0]   in_row;
  logic [COORD_W-1:0]   in_column;
  logic [PIX_W-1:0]     in_pixel_in;
  logic                 out_valid;
  logic [PIX_W-1:0]     out_pixel_out;
  logic                 out_out_of_range;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_wdata;

  // Scaler model: geometry registers and the frame contents as the block holds them.
  logic [SIZE_W-1:0]  width_reg  = SIZE_RESET;
  logic [SIZE_W-1:0]  height_reg = SIZE_RESET;
  logic [SCALE_W-1:0] hscale_reg = SCALE_RESET;
  logic [SCALE_W-1:0] vscale_reg = SCALE_RESET;
  logic [PIX_W-1:0]   frame_image [DEPTH];
  scaled_px_t         pending_pixels [$];

  // Source positions that the stimulus has already written; reads only land on these.
  bit filled [DEPTH];

  bit gaps_on = 1'b1;
  int mismatches = 0;
  int words_sent = 0;
  int reads_checked = 0;
  int flagged_seen = 0;
  int settings_used = 0;

  nearest_neighbour_image_scaler_core dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_opcode        (in_opcode),
    .in_row           (in_row),
    .in_column        (in_column),
    .in_pixel_in      (in_pixel_in),
    .out_valid        (out_valid),
    .out_pixel_out    (out_pixel_out),
    .out_out_of_range (out_out_of_range),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata)
  );

  always #10 clk = ~clk;

  function automatic int unsigned eff_side(input logic [SIZE_W-1:0] v);
    if (v == '0) return 1;
    if (v > MAX_SIDE) return MAX_SIDE;
    return 32'(v);
  endfunction

  function automatic int unsigned scaled_extent(input int unsigned side,
                                                input logic [SCALE_W-1:0] s);
    return (side * s) >> SCALE_FRAC;
  endfunction

  // Divide by the scale and round; an exact half rounds down.
  function automatic int unsigned source_index(input int unsigned c,
                                               input logic [SCALE_W-1:0] s,
                                               input int unsigned side);
    int unsigned num, q, r;
    num = c << SCALE_FRAC;
    q = num / s;
    r = num % s;
    if (2 * r > s) q++;
    if (q > side - 1) q = side - 1;
    return q;
  endfunction

  // Returns 1 and the frame address when the output position lies inside the scaled image.
  function automatic bit map_read(input int unsigned r, input int unsigned c,
                                  output int unsigned addr);
    int unsigned w, h;
    w = eff_side(width_reg);
    h = eff_side(height_reg);
    addr = 0;
    if (hscale_reg == '0 || vscale_reg == '0) return 1'b0;
    if (c >= scaled_extent(w, hscale_reg) || r >= scaled_extent(h, vscale_reg)) return 1'b0;
    addr = source_index(r, vscale_reg, h) * MAX_SIDE + source_index(c, hscale_reg, w);
    return 1'b1;
  endfunction

  // Checks the result word of this edge, then takes in a register write or an accepted word.
  always @(posedge clk) begin : scoreboard
    scaled_px_t  want;
    int unsigned addr;
    if (rst_n) begin
      if (out_valid) begin
        if (pending_pixels.size() == 0) begin
          $error("result word with nothing expected: pixel_out=%h out_of_range=%b",
                 out_pixel_out, out_out_of_range);
          mismatches++;
        end else begin
          want = pending_pixels.pop_front();
          reads_checked++;
          if (out_out_of_range) flagged_seen++;
          if (out_pixel_out !== want.pixel) begin
            $error("pixel_out: expected %h, got %h", want.pixel, out_pixel_out);
            mismatches++;
          end
          if (out_out_of_range !== want.flagged) begin
            $error("out_of_range: expected %b, got %b", want.flagged, out_out_of_range);
            mismatches++;
          end
        end
      end
      if (cfg_we) begin
        case (cfg_reg_t'(cfg_index))
          REG_SRC_WIDTH:  width_reg  = cfg_wdata[SIZE_W-1:0];
          REG_SRC_HEIGHT: height_reg = cfg_wdata[SIZE_W-1:0];
          REG_H_SCALE:    hscale_reg = cfg_wdata[SCALE_W-1:0];
          REG_V_SCALE:    vscale_reg = cfg_wdata[SCALE_W-1:0];
          default: ;
        endcase
      end
      if (start && !busy) begin
        if (opcode_t'(in_opcode) == OP_WRITE) begin
          if (in_row < eff_side(height_reg) && in_column < eff_side(width_reg))
            frame_image[int'(in_row) * MAX_SIDE + int'(in_column)] = in_pixel_in;
        end else if (map_read(32'(in_row), 32'(in_column), addr)) begin
          want.pixel = frame_image[addr];
          want.flagged = 1'b0;
          pending_pixels.push_back(want);
        end else begin
          want.pixel = '0;
          want.flagged = 1'b1;
          pending_pixels.push_back(want);
        end
      end
    end
  end

  task automatic send_word(input opcode_t op, input int unsigned r, input int unsigned c,
                           input logic [PIX_W-1:0] pix);
    @(negedge clk);
    if (gaps_on && $urandom_range(99) < 5) begin
      start <= 1'b0;
      repeat ($urandom_range(4, 1)) @(negedge clk);
    end
    start       <= 1'b1;
    in_opcode   <= op;
    in_row      <= COORD_W'(r);
    in_column   <= COORD_W'(c);
    in_pixel_in <= pix;
    do @(posedge clk); while (busy);
    words_sent++;
  endtask

  task automatic write_pixel(input int unsigned r, input int unsigned c,
                             input logic [PIX_W-1:0] pix);
    if (r < eff_side(height_reg) && c < eff_side(width_reg))
      filled[r * MAX_SIDE + c] = 1'b1;
    send_word(OP_WRITE, r, c, pix);
  endtask

  // A read whose source pixel was never written gets that pixel written first.
  task automatic read_pixel(input int unsigned r, input int unsigned c);
    int unsigned addr;
    if (map_read(r, c, addr) && !filled[addr])
      write_pixel(addr / MAX_SIDE, addr % MAX_SIDE, PIX_W'($urandom));
    send_word(OP_READ, r, c, PIX_W'($urandom));
  endtask

  // Stops issuing words and waits until every expected result has come and writes have landed.
  task automatic drain_results();
    int waited;
    waited = 0;
    @(negedge clk);
    start <= 1'b0;
    while (pending_pixels.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    if (pending_pixels.size() != 0) begin
      $error("%0d expected result words never arrived", pending_pixels.size());
      mismatches += pending_pixels.size();
      pending_pixels.delete();
    end
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_register(input cfg_reg_t idx, input logic [CFG_W-1:0] value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  task automatic set_geometry(input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] h,
                              input logic [CFG_W-1:0] hs, input logic [CFG_W-1:0] vs);
    drain_results();
    write_register(REG_SRC_WIDTH, w);
    write_register(REG_SRC_HEIGHT, h);
    write_register(REG_H_SCALE, hs);
    write_register(REG_V_SCALE, vs);
    settings_used++;
  endtask

  function automatic logic [CFG_W-1:0] random_side();
    logic [CFG_W-1:0] v;
    case ($urandom_range(9))
      0:       v = '0;
      1:       v = CFG_W'($urandom_range(511, MAX_SIDE + 1));
      2:       v = CFG_W'(MAX_SIDE);
      default: v = CFG_W'($urandom_range(48, 1));
    endcase
    // Bits above the size field are don't-care, so fill them with noise.
    v[CFG_W-1:SIZE_W] = (CFG_W - SIZE_W)'($urandom);
    return v;
  endfunction

  function automatic logic [CFG_W-1:0] random_scale();
    case ($urandom_range(19))
      0:       return '0;
      1:       return '1;
      2:       return CFG_W'($urandom_range(65535, 1));
      default: return CFG_W'($urandom_range(16384, 1024));
    endcase
  endfunction

  // Reset geometry: corners, extreme pixel values, and writes past the edge that must not wrap.
  task automatic test_default_geometry();
    write_pixel(0, 0, '0);
    write_pixel(0, 255, '1);
    write_pixel(255, 0, 24'hA5C35A);
    write_pixel(255, 255, 24'h5A3CA5);
    write_pixel(256, 0, 24'h123456);
    write_pixel(0, 256, 24'h654321);
    write_pixel(4095, 4095, '1);
    read_pixel(0, 0);
    read_pixel(0, 255);
    read_pixel(255, 0);
    read_pixel(255, 255);
    read_pixel(256, 0);
    read_pixel(0, 4095);
  endtask

  // Size saturation, zero scales and the largest scale.
  task automatic test_register_extremes();
    set_geometry('0, '1, '0, CFG_W'(4096));
    read_pixel(0, 0);
    set_geometry(CFG_W'(256), CFG_W'(256), CFG_W'(4096), '0);
    read_pixel(0, 0);
    set_geometry(CFG_W'(1), CFG_W'(1), '1, '1);
    read_pixel(0, 0);
    read_pixel(14, 14);
    read_pixel(15, 0);
    set_geometry(CFG_W'(256), CFG_W'(256), CFG_W'(1), CFG_W'(1));
    read_pixel(0, 0);
  endtask

  // Exact halves round down, larger fractions round up, and overshoot clamps to the edge.
  task automatic test_rounding_and_clamp();
    set_geometry(CFG_W'(4), CFG_W'(4), CFG_W'(8192), CFG_W'(12288));
    read_pixel(0, 1);
    read_pixel(0, 3);
    read_pixel(2, 7);
    read_pixel(11, 0);
    read_pixel(11, 7);
    set_geometry(CFG_W'(2), CFG_W'(2), CFG_W'(12288), CFG_W'(12288));
    read_pixel(5, 5);
  endtask

  // Each phase sends a fixed share of words, counting the writes that reads pull in.
  task automatic test_random_traffic();
    int unsigned out_w, out_h, w, h;
    int          pick;
    int          phase_end, phase_half;
    bit          drained;
    for (int phase = 0; phase < PHASES; phase++) begin
      set_geometry(random_side(), random_side(), random_scale(), random_scale());
      gaps_on = (phase != 3);
      w = eff_side(width_reg);
      h = eff_side(height_reg);
      out_w = scaled_extent(w, hscale_reg);
      out_h = scaled_extent(h, vscale_reg);
      phase_end  = words_sent + PHASE_WORDS;
      phase_half = words_sent + PHASE_WORDS / 2;
      drained    = 1'b0;
      while (words_sent < phase_end) begin
        if (phase % 2 == 1 && !drained && words_sent >= phase_half) begin
          drain_results();
          drained = 1'b1;
        end
        pick = $urandom_range(99);
        if (pick < 55 && out_w > 0 && out_h > 0)
          read_pixel($urandom_range(out_h - 1), $urandom_range(out_w - 1));
        else if (pick < 70)
          read_pixel($urandom_range(4095), $urandom_range(4095));
        else if (pick < 95)
          write_pixel($urandom_range(h - 1), $urandom_range(w - 1), PIX_W'($urandom));
        else
          write_pixel($urandom_range(4095), $urandom_range(4095), PIX_W'($urandom));
      end
    end
    gaps_on = 1'b1;
  endtask

  initial begin
    rst_n       <= 1'b0;
    start       <= 1'b0;
    in_opcode   <= OP_WRITE;
    in_row      <= '0;
    in_column   <= '0;
    in_pixel_in <= '0;
    cfg_we      <= 1'b0;
    cfg_index   <= REG_SRC_WIDTH;
    cfg_wdata   <= '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_default_geometry();
    test_register_extremes();
    test_rounding_and_clamp();
    test_random_traffic();
    drain_results();

    $display("Sent %0d words under %0d geometry settings after reset.",
             words_sent, settings_used);
    $display("Checked %0d read results, %0d of them outside the scaled image.",
             reads_checked, flagged_seen);
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #2ms;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
